// ----- hdl/etff_pkg.sv -----
// ----------------------------------------------------------------------------
// etff_pkg
// Shared types, constants and codes for the telemetry frame filter.
// ----------------------------------------------------------------------------
package etff_pkg;

   // Framing
   localparam logic [7:0] SYNC_BYTE   = 8'h9B;
   localparam int         FRAME_LEN   = 18;
   localparam int         COUNT_W     = 5;
   localparam int         FIRST_USED  = 3;
   localparam int         LAST_USED   = 16;

   // Frame checks
   localparam logic [15:0] LIMIT_DUTY  = 16'd1024;
   localparam logic [23:0] LIMIT_RPM   = 24'd200000;
   localparam logic [7:0]  NIBBLE_MASK = 8'hF0;

   // Filter arithmetic
   localparam int         ALPHA_W     = 9;
   localparam logic [8:0] ALPHA_MAX   = 9'd256;
   localparam logic [8:0] ALPHA_RESET = 9'd26;
   localparam int         ALPHA_SHIFT = 8;
   localparam int         FRAC_BITS   = 8;

   // Field widths
   localparam int RAW16_W   = 16;
   localparam int RAW_RPM_W = 24;
   localparam int AVG_DUTY_W = 19;
   localparam int AVG_RPM_W  = 26;
   localparam int AVG_ADC_W  = 20;

   // Queue between parser and filter
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic                 ok;
      logic [RAW16_W-1:0]   throttle;
      logic [RAW16_W-1:0]   pwm;
      logic [RAW_RPM_W-1:0] rpm;
      logic [RAW16_W-1:0]   voltage;
      logic [RAW16_W-1:0]   current;
      logic [RAW16_W-1:0]   temperature;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic diff_en;
      logic mul_en;
      logic upd_en;
   } lane_ctrl_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_DIFF,
      BE_MUL,
      BE_UPD
   } back_state_type;

endpackage

// ----- hdl/etff_front.sv -----
// ----------------------------------------------------------------------------
// etff_front
// Byte parser: hunts for sync, collects a frame and checks its fields.
// ----------------------------------------------------------------------------
module etff_front
   import etff_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_accept,
   input  logic [7:0] rx_byte,
   output logic       push,
   output frame_type  frame
);

   logic [COUNT_W-1:0] byte_count_ff;
   logic [COUNT_W-1:0] byte_count_in;
   logic [7:0]         frame_ff [FIRST_USED:LAST_USED];
   logic               last_byte;

   assign last_byte = (byte_count_ff == COUNT_W'(FRAME_LEN));
   assign push      = byte_accept && last_byte;

   always_comb begin
      byte_count_in = byte_count_ff;
      if (byte_accept) begin
         if (byte_count_ff == '0) begin
            byte_count_in = (rx_byte == SYNC_BYTE) ? COUNT_W'(1) : '0;
         end else if (byte_count_ff < COUNT_W'(FRAME_LEN)) begin
            byte_count_in = byte_count_ff + COUNT_W'(1);
         end else begin
            byte_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

   // Keep only the frame bytes that carry fields
   always_ff @(posedge clock) begin
      for (int i = FIRST_USED; i <= LAST_USED; i++) begin
         if (byte_accept && byte_count_ff == COUNT_W'(i + 1)) begin
            frame_ff[i] <= rx_byte;
         end
      end
   end

   always_comb begin
      frame.throttle    = {frame_ff[3], frame_ff[4]};
      frame.pwm         = {frame_ff[5], frame_ff[6]};
      frame.rpm         = {frame_ff[7], frame_ff[8], frame_ff[9]};
      frame.voltage     = {frame_ff[10], frame_ff[11]};
      frame.current     = {frame_ff[12], frame_ff[13]};
      frame.temperature = {frame_ff[14], frame_ff[15]};
      frame.ok = !((frame.throttle > LIMIT_DUTY) || (frame.pwm > LIMIT_DUTY) ||
                   (frame.rpm > LIMIT_RPM) ||
                   ((frame_ff[10] & NIBBLE_MASK) != '0) ||
                   ((frame_ff[12] & NIBBLE_MASK) != '0) ||
                   ((frame_ff[14] & NIBBLE_MASK) != '0) ||
                   ((frame_ff[16] & NIBBLE_MASK) != '0));
   end

endmodule

// ----- hdl/etff_queue.sv -----
// ----------------------------------------------------------------------------
// etff_queue
// Short register queue of parsed frames between parser and filter.
// ----------------------------------------------------------------------------
module etff_queue
   import etff_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_type        push_frame,
   input  logic             pop,
   output frame_type        head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ----- hdl/etff_ema_lane.sv -----
// ----------------------------------------------------------------------------
// etff_ema_lane
// One moving average: difference, multiply by alpha, then add and clamp.
// ----------------------------------------------------------------------------
module etff_ema_lane
   import etff_pkg::*;
#(
   parameter int RAW_W = RAW16_W,
   parameter int AVG_W = AVG_ADC_W
)
(
   input  logic               clock,
   input  logic               reset,
   input  lane_ctrl_type      ctrl,
   input  logic [ALPHA_W-1:0] alpha,
   input  logic [RAW_W-1:0]   raw,
   output logic [AVG_W-1:0]   avg,
   output logic [AVG_W-1:0]   avg_next
);

   localparam int TGT_W  = RAW_W + FRAC_BITS;
   localparam int MAG_W  = (TGT_W > AVG_W) ? TGT_W : AVG_W;
   localparam int DIFF_W = MAG_W + 1;
   localparam int PROD_W = DIFF_W + ALPHA_W + 1;

   logic        [AVG_W-1:0]  filt_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] step_w;
   logic signed [PROD_W-1:0] sum_w;
   logic        [DIFF_W-1:0] tgt_ext;
   logic        [DIFF_W-1:0] filt_ext;

   assign avg      = filt_ff;
   assign tgt_ext  = {{(DIFF_W - TGT_W){1'b0}}, raw, {FRAC_BITS{1'b0}}};
   assign filt_ext = {{(DIFF_W - AVG_W){1'b0}}, filt_ff};

   // Floor division by 256 is an arithmetic shift
   assign step_w = prod_ff >>> ALPHA_SHIFT;
   assign sum_w  = $signed({{(PROD_W - AVG_W){1'b0}}, filt_ff}) + step_w;

   always_comb begin
      if (sum_w[PROD_W-1]) begin
         avg_next = '0;
      end else if (|sum_w[PROD_W-2:AVG_W]) begin
         avg_next = '1;
      end else begin
         avg_next = sum_w[AVG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.diff_en) begin
         diff_ff <= $signed(tgt_ext) - $signed(filt_ext);
      end
      if (ctrl.mul_en) begin
         prod_ff <= $signed({1'b0, alpha}) * diff_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
      end else if (ctrl.upd_en) begin
         filt_ff <= avg_next;
      end
   end

endmodule

// ----- hdl/etff_back.sv -----
// ----------------------------------------------------------------------------
// etff_back
// Filter sequencer: takes a parsed frame, updates six averages if it passed, emits result.
// ----------------------------------------------------------------------------
module etff_back
   import etff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ALPHA_W-1:0]    alpha,
   input  queue_status_type      q_status,
   input  frame_type             head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_frame_ok,
   output logic [AVG_DUTY_W-1:0] rsp_avg_throttle,
   output logic [AVG_DUTY_W-1:0] rsp_avg_pwm,
   output logic [AVG_RPM_W-1:0]  rsp_avg_rpm,
   output logic [AVG_ADC_W-1:0]  rsp_avg_voltage,
   output logic [AVG_ADC_W-1:0]  rsp_avg_current,
   output logic [AVG_ADC_W-1:0]  rsp_avg_temperature
);

   back_state_type state_ff;
   back_state_type state_in;
   frame_type      cur_ff;
   lane_ctrl_type  ctrl;
   logic           out_free;
   logic           load_out;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   logic                  rsp_frame_ok_ff;
   logic [AVG_DUTY_W-1:0] rsp_thr_ff,  avg_thr,  nxt_thr;
   logic [AVG_DUTY_W-1:0] rsp_pwm_ff,  avg_pwm,  nxt_pwm;
   logic [AVG_RPM_W-1:0]  rsp_rpm_ff,  avg_rpm,  nxt_rpm;
   logic [AVG_ADC_W-1:0]  rsp_volt_ff, avg_volt, nxt_volt;
   logic [AVG_ADC_W-1:0]  rsp_curr_ff, avg_curr, nxt_curr;
   logic [AVG_ADC_W-1:0]  rsp_temp_ff, avg_temp, nxt_temp;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      load_out     = 1'b0;
      ctrl         = '0;
      unique case (state_ff)
         BE_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               state_in = BE_DIFF;
            end
         end
         BE_DIFF: begin
            ctrl.diff_en = 1'b1;
            state_in     = BE_MUL;
         end
         BE_MUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = BE_UPD;
         end
         BE_UPD: begin
            if (out_free) begin
               load_out    = 1'b1;
               ctrl.upd_en = cur_ff.ok;
               state_in    = BE_IDLE;
            end
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   etff_ema_lane #(.RAW_W(RAW16_W), .AVG_W(AVG_DUTY_W)) u_lane_thr (
      .clock(clock), .reset(reset), .ctrl(ctrl), .alpha(alpha),
      .raw(cur_ff.throttle), .avg(avg_thr), .avg_next(nxt_thr));

   etff_ema_lane #(.RAW_W(RAW16_W), .AVG_W(AVG_DUTY_W)) u_lane_pwm (
      .clock(clock), .reset(reset), .ctrl(ctrl), .alpha(alpha),
      .raw(cur_ff.pwm), .avg(avg_pwm), .avg_next(nxt_pwm));

   etff_ema_lane #(.RAW_W(RAW_RPM_W), .AVG_W(AVG_RPM_W)) u_lane_rpm (
      .clock(clock), .reset(reset), .ctrl(ctrl), .alpha(alpha),
      .raw(cur_ff.rpm), .avg(avg_rpm), .avg_next(nxt_rpm));

   etff_ema_lane #(.RAW_W(RAW16_W), .AVG_W(AVG_ADC_W)) u_lane_volt (
      .clock(clock), .reset(reset), .ctrl(ctrl), .alpha(alpha),
      .raw(cur_ff.voltage), .avg(avg_volt), .avg_next(nxt_volt));

   etff_ema_lane #(.RAW_W(RAW16_W), .AVG_W(AVG_ADC_W)) u_lane_curr (
      .clock(clock), .reset(reset), .ctrl(ctrl), .alpha(alpha),
      .raw(cur_ff.current), .avg(avg_curr), .avg_next(nxt_curr));

   etff_ema_lane #(.RAW_W(RAW16_W), .AVG_W(AVG_ADC_W)) u_lane_temp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .alpha(alpha),
      .raw(cur_ff.temperature), .avg(avg_temp), .avg_next(nxt_temp));

   // Report updated averages for a good frame, held ones for a bad one
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_frame_ok_ff <= cur_ff.ok;
         rsp_thr_ff      <= cur_ff.ok ? nxt_thr  : avg_thr;
         rsp_pwm_ff      <= cur_ff.ok ? nxt_pwm  : avg_pwm;
         rsp_rpm_ff      <= cur_ff.ok ? nxt_rpm  : avg_rpm;
         rsp_volt_ff     <= cur_ff.ok ? nxt_volt : avg_volt;
         rsp_curr_ff     <= cur_ff.ok ? nxt_curr : avg_curr;
         rsp_temp_ff     <= cur_ff.ok ? nxt_temp : avg_temp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_ok        = rsp_frame_ok_ff;
   assign rsp_avg_throttle    = rsp_thr_ff;
   assign rsp_avg_pwm         = rsp_pwm_ff;
   assign rsp_avg_rpm         = rsp_rpm_ff;
   assign rsp_avg_voltage     = rsp_volt_ff;
   assign rsp_avg_current     = rsp_curr_ff;
   assign rsp_avg_temperature = rsp_temp_ff;

endmodule

// ----- hdl/esc_telemetry_frame_filter_core.sv -----
// ----------------------------------------------------------------------------
// esc_telemetry_frame_filter_core
// Telemetry frame parser with six exponential moving averages.
// ----------------------------------------------------------------------------
// Feed one received UART byte per item on req_. Bytes are dropped until the
// sync byte 0x9B; the next 18 bytes form a frame, and one result item leaves
// on rsp_ per frame. A frame passes when throttle and pwm are at most 1024,
// rpm at most 200000 and the high nibble of bytes 10, 12, 14 and 16 is clear;
// a passing frame updates the averages, a failing one reports them unchanged
// with frame_ok low. Averages carry 8 fraction bits and follow
// f += floor(alpha * (raw * 256 - f) / 256), clamped to the field width.
// Rate: one byte per cycle while the frame queue is not full. A completed
// frame enters a two-entry queue, and the filter sequencer takes it through
// pop, difference, multiply, then add and clamp, and registers its result
// once the output is free. Frames are at least 19 bytes apart, so the
// sequencer keeps up unless rsp_stall holds the output. Write alpha
// through csr_ only while no frame is in flight; values above 256 act as 256.
// ----------------------------------------------------------------------------
module esc_telemetry_frame_filter_core
   import etff_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_frame_ok,
   output logic [AVG_DUTY_W-1:0] rsp_avg_throttle,
   output logic [AVG_DUTY_W-1:0] rsp_avg_pwm,
   output logic [AVG_RPM_W-1:0]  rsp_avg_rpm,
   output logic [AVG_ADC_W-1:0]  rsp_avg_voltage,
   output logic [AVG_ADC_W-1:0]  rsp_avg_current,
   output logic [AVG_ADC_W-1:0]  rsp_avg_temperature,

   input  logic                  csr_wr_en,
   input  logic [ALPHA_W-1:0]    csr_wr_data
);

   logic [ALPHA_W-1:0] alpha_ff;
   logic [ALPHA_W-1:0] alpha_sat;
   logic               byte_accept;
   logic               q_push;
   logic               q_pop;
   frame_type          front_frame;
   frame_type          q_head;
   queue_status_type   q_status;

   // Hold alpha; the user must change it only while the block is idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else if (csr_wr_en) begin
         alpha_ff <= csr_wr_data;
      end
   end

   // Saturate alpha at 256, meaning no smoothing
   assign alpha_sat = (alpha_ff > ALPHA_MAX) ? ALPHA_MAX : alpha_ff;

   // Stall the byte stream only while the frame queue is full
   assign req_stall   = q_status.full;
   assign byte_accept = req_valid && !req_stall;

   etff_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .push        (q_push),
      .frame       (front_frame)
   );

   etff_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_frame (front_frame),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   etff_back u_back (
      .clock               (clock),
      .reset               (reset),
      .alpha               (alpha_sat),
      .q_status            (q_status),
      .head                (q_head),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_avg_throttle    (rsp_avg_throttle),
      .rsp_avg_pwm         (rsp_avg_pwm),
      .rsp_avg_rpm         (rsp_avg_rpm),
      .rsp_avg_voltage     (rsp_avg_voltage),
      .rsp_avg_current     (rsp_avg_current),
      .rsp_avg_temperature (rsp_avg_temperature)
   );

   // A completed frame never lands in a full queue
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("frame pushed into full queue");

   // The filter only takes a frame that is there
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("frame popped from empty queue");

   // Queue occupancy stays consistent
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

endmodule

// ----- bench/frame_filter_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_filter_monitor
// Watches the byte and result channels of the telemetry frame filter, tracks
// the sync hunt and the six moving averages on its own, and compares every
// result item against the oldest predicted one.
// ----------------------------------------------------------------------------
module frame_filter_monitor
   import etff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_rx_byte,

   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_frame_ok,
   input  logic [AVG_DUTY_W-1:0] rsp_avg_throttle,
   input  logic [AVG_DUTY_W-1:0] rsp_avg_pwm,
   input  logic [AVG_RPM_W-1:0]  rsp_avg_rpm,
   input  logic [AVG_ADC_W-1:0]  rsp_avg_voltage,
   input  logic [AVG_ADC_W-1:0]  rsp_avg_current,
   input  logic [AVG_ADC_W-1:0]  rsp_avg_temperature,

   input  logic                  csr_wr_en,
   input  logic [ALPHA_W-1:0]    csr_wr_data,

   output int                    mismatch_count,
   output int                    frames_pending,
   output int                    frames_checked,
   output int                    frames_passed
);

   typedef struct packed {
      logic                  ok;
      logic [AVG_DUTY_W-1:0] throttle;
      logic [AVG_DUTY_W-1:0] pwm;
      logic [AVG_RPM_W-1:0]  rpm;
      logic [AVG_ADC_W-1:0]  voltage;
      logic [AVG_ADC_W-1:0]  current;
      logic [AVG_ADC_W-1:0]  temperature;
   } averages_type;

   averages_type         expected_averages[$];
   averages_type         due;
   averages_type         next_avg;
   logic [ALPHA_W-1:0]   alpha_reg;
   int                   parse_count;
   logic [7:0]           frame_buf [FRAME_LEN];
   logic [RAW16_W-1:0]   raw_thr, raw_pwm, raw_volt, raw_curr, raw_temp;
   logic [RAW_RPM_W-1:0] raw_rpm;
   logic                 frame_pass;
   longint               avg_thr, avg_pwm, avg_rpm, avg_volt, avg_curr, avg_temp;

   initial begin
      mismatch_count = 0;
      frames_pending = 0;
      frames_checked = 0;
      frames_passed  = 0;
   end

   // one smoothing step, floor rounding, clamped to the field width
   function automatic longint ema_update(input longint avg, input longint raw,
                                         input int width);
      longint gain, step, ceiling;
      gain    = (alpha_reg > ALPHA_MAX) ? longint'(ALPHA_MAX) : longint'(alpha_reg);
      step    = (gain * ((raw <<< FRAC_BITS) - avg)) >>> ALPHA_SHIFT;
      ceiling = (longint'(1) <<< width) - 1;
      avg     = avg + step;
      if (avg < 0) avg = 0;
      if (avg > ceiling) avg = ceiling;
      return avg;
   endfunction

   task automatic report_error(input string msg);
      if (mismatch_count < 40) $display("[%0t] frame check: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("frame %0d %s: got %0d, expected %0d",
                                frames_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         alpha_reg   = ALPHA_RESET;
         parse_count = 0;
         avg_thr     = 0;
         avg_pwm     = 0;
         avg_rpm     = 0;
         avg_volt    = 0;
         avg_curr    = 0;
         avg_temp    = 0;
         expected_averages.delete();
      end else begin
         if (csr_wr_en) alpha_reg = csr_wr_data;

         if (rsp_valid && !rsp_stall) begin
            if (expected_averages.size() == 0) begin
               report_error("result item with no frame awaiting it");
            end else begin
               due = expected_averages.pop_front();
               compare_field("frame_ok", rsp_frame_ok, due.ok);
               compare_field("avg_throttle", rsp_avg_throttle, due.throttle);
               compare_field("avg_pwm", rsp_avg_pwm, due.pwm);
               compare_field("avg_rpm", rsp_avg_rpm, due.rpm);
               compare_field("avg_voltage", rsp_avg_voltage, due.voltage);
               compare_field("avg_current", rsp_avg_current, due.current);
               compare_field("avg_temperature", rsp_avg_temperature, due.temperature);
               frames_checked++;
            end
         end

         if (req_valid && !req_stall) begin
            if (parse_count == 0) begin
               if (req_rx_byte == SYNC_BYTE) parse_count = 1;
            end else if (parse_count < FRAME_LEN) begin
               frame_buf[parse_count-1] = req_rx_byte;
               parse_count++;
            end else begin
               frame_buf[FRAME_LEN-1] = req_rx_byte;
               parse_count = 0;
               raw_thr  = {frame_buf[3], frame_buf[4]};
               raw_pwm  = {frame_buf[5], frame_buf[6]};
               raw_rpm  = {frame_buf[7], frame_buf[8], frame_buf[9]};
               raw_volt = {frame_buf[10], frame_buf[11]};
               raw_curr = {frame_buf[12], frame_buf[13]};
               raw_temp = {frame_buf[14], frame_buf[15]};
               frame_pass = (raw_thr <= LIMIT_DUTY) && (raw_pwm <= LIMIT_DUTY) &&
                            (raw_rpm <= LIMIT_RPM) &&
                            ((frame_buf[10] & NIBBLE_MASK) == 8'h00) &&
                            ((frame_buf[12] & NIBBLE_MASK) == 8'h00) &&
                            ((frame_buf[14] & NIBBLE_MASK) == 8'h00) &&
                            ((frame_buf[16] & NIBBLE_MASK) == 8'h00);
               if (frame_pass) begin
                  avg_thr  = ema_update(avg_thr, raw_thr, AVG_DUTY_W);
                  avg_pwm  = ema_update(avg_pwm, raw_pwm, AVG_DUTY_W);
                  avg_rpm  = ema_update(avg_rpm, raw_rpm, AVG_RPM_W);
                  avg_volt = ema_update(avg_volt, raw_volt, AVG_ADC_W);
                  avg_curr = ema_update(avg_curr, raw_curr, AVG_ADC_W);
                  avg_temp = ema_update(avg_temp, raw_temp, AVG_ADC_W);
                  frames_passed++;
               end
               next_avg.ok          = frame_pass;
               next_avg.throttle    = avg_thr[AVG_DUTY_W-1:0];
               next_avg.pwm         = avg_pwm[AVG_DUTY_W-1:0];
               next_avg.rpm         = avg_rpm[AVG_RPM_W-1:0];
               next_avg.voltage     = avg_volt[AVG_ADC_W-1:0];
               next_avg.current     = avg_curr[AVG_ADC_W-1:0];
               next_avg.temperature = avg_temp[AVG_ADC_W-1:0];
               expected_averages.push_back(next_avg);
            end
         end
      end
      frames_pending <= expected_averages.size();
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus and verdict for the telemetry frame filter.
// ----------------------------------------------------------------------------
// Feeds serial bytes in random bursts: a few directed frames first (field
// limits, each frame check on its own, sync bytes inside a frame, alpha at
// zero, full scale and above full scale), then mostly well-formed frames with
// random content mixed with flawed frames, random frames and line noise,
// across several alpha settings. The result side stalls on its own pattern.
// The monitor beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
   import etff_pkg::*;

   typedef enum int {
      FLAW_NONE,
      FLAW_THROTTLE,
      FLAW_PWM,
      FLAW_RPM,
      FLAW_VOLTAGE,
      FLAW_CURRENT,
      FLAW_TEMPERATURE,
      FLAW_SPARE
   } flaw_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_MOSTLY,
      STALL_RUNS
   } stall_mode_type;

   localparam int PHASE_BYTES = 255;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic [7:0]            req_rx_byte = 8'h00;
   logic                  rsp_stall   = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [ALPHA_W-1:0]    csr_wr_data = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_frame_ok;
   logic [AVG_DUTY_W-1:0] rsp_avg_throttle;
   logic [AVG_DUTY_W-1:0] rsp_avg_pwm;
   logic [AVG_RPM_W-1:0]  rsp_avg_rpm;
   logic [AVG_ADC_W-1:0]  rsp_avg_voltage;
   logic [AVG_ADC_W-1:0]  rsp_avg_current;
   logic [AVG_ADC_W-1:0]  rsp_avg_temperature;

   int mismatch_count;
   int frames_pending;
   int frames_checked;
   int frames_passed;

   // body of the next frame, sync byte not included
   logic [7:0] frame_body [FRAME_LEN];

   // sender's own view of the parser: 0 while hunting, else frame position
   int frame_pos        = 0;
   int frame_bytes_sent = 0;
   int dropped_bytes    = 0;
   int burst_left       = 0;
   int settings_used    = 0;

   logic [ALPHA_W-1:0] alpha_plan [6] = '{9'd1, 9'd128, 9'd255, 9'd300, 9'd0, 9'd26};

   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             stall_tick = 0;

   esc_telemetry_frame_filter_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_avg_throttle    (rsp_avg_throttle),
      .rsp_avg_pwm         (rsp_avg_pwm),
      .rsp_avg_rpm         (rsp_avg_rpm),
      .rsp_avg_voltage     (rsp_avg_voltage),
      .rsp_avg_current     (rsp_avg_current),
      .rsp_avg_temperature (rsp_avg_temperature),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   frame_filter_monitor monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_avg_throttle    (rsp_avg_throttle),
      .rsp_avg_pwm         (rsp_avg_pwm),
      .rsp_avg_rpm         (rsp_avg_rpm),
      .rsp_avg_voltage     (rsp_avg_voltage),
      .rsp_avg_current     (rsp_avg_current),
      .rsp_avg_temperature (rsp_avg_temperature),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .mismatch_count      (mismatch_count),
      .frames_pending      (frames_pending),
      .frames_checked      (frames_checked),
      .frames_passed       (frames_passed)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Run guard: far beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("Timeout: %0d frames still awaited", frames_pending);
      $display("Test completed with failures");
      $finish;
   end

   // Result side back-pressure: every so often pick a new stall mode, from
   // no stall at all to long stall runs.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 150);
      end else begin
         stall_left--;
      end
      stall_tick++;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= 1'($urandom_range(0, 1));
         STALL_MOSTLY: rsp_stall <= (stall_tick % 4) != 0;
         default:      rsp_stall <= (stall_tick % 16) < 10;
      endcase
   end

   // Offer one byte, hold it until taken, then advance the parser view and
   // drop valid for a random gap once the current burst runs out.
   task automatic push_byte(input logic [7:0] b);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (frame_pos == 0 && b != SYNC_BYTE) dropped_bytes++;
      else frame_bytes_sent++;
      if (frame_pos == 0) begin
         if (b == SYNC_BYTE) frame_pos = 1;
      end else if (frame_pos == FRAME_LEN) begin
         frame_pos = 0;
      end else begin
         frame_pos++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         // one burst in four is a long stretch with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Lay out the big-endian fields; the unused bytes get random filler.
   task automatic fill_frame(input logic [15:0] thr, input logic [15:0] pwm,
                             input logic [23:0] rpm, input logic [15:0] volt,
                             input logic [15:0] curr, input logic [15:0] temp,
                             input logic [7:0] spare);
      foreach (frame_body[i]) frame_body[i] = 8'($urandom_range(0, 255));
      frame_body[3]  = thr[15:8];
      frame_body[4]  = thr[7:0];
      frame_body[5]  = pwm[15:8];
      frame_body[6]  = pwm[7:0];
      frame_body[7]  = rpm[23:16];
      frame_body[8]  = rpm[15:8];
      frame_body[9]  = rpm[7:0];
      frame_body[10] = volt[15:8];
      frame_body[11] = volt[7:0];
      frame_body[12] = curr[15:8];
      frame_body[13] = curr[7:0];
      frame_body[14] = temp[15:8];
      frame_body[15] = temp[7:0];
      frame_body[16] = spare;
   endtask

   task automatic send_frame();
      push_byte(SYNC_BYTE);
      foreach (frame_body[i]) push_byte(frame_body[i]);
   endtask

   function automatic logic [15:0] pick_duty();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return LIMIT_DUTY;
         default: return 16'($urandom_range(0, 1024));
      endcase
   endfunction

   // Random in-range frame, with at most one check broken on purpose.
   task automatic send_sample_frame(input flaw_type flaw);
      logic [15:0] thr, pwm, volt, curr, temp;
      logic [23:0] rpm;
      logic [7:0]  spare;
      thr   = pick_duty();
      pwm   = pick_duty();
      rpm   = ($urandom_range(0, 9) == 0) ? LIMIT_RPM : 24'($urandom_range(0, 200000));
      volt  = 16'($urandom_range(0, 4095));
      curr  = 16'($urandom_range(0, 4095));
      temp  = 16'($urandom_range(0, 4095));
      spare = 8'($urandom_range(0, 15));
      case (flaw)
         FLAW_THROTTLE:
            thr = ($urandom_range(0, 3) == 0) ? LIMIT_DUTY + 16'd1
                                              : 16'($urandom_range(1025, 65535));
         FLAW_PWM:
            pwm = ($urandom_range(0, 3) == 0) ? LIMIT_DUTY + 16'd1
                                              : 16'($urandom_range(1025, 65535));
         FLAW_RPM:
            rpm = ($urandom_range(0, 3) == 0) ? LIMIT_RPM + 24'd1
                                              : 24'($urandom_range(200001, 24'hFFFFFF));
         FLAW_VOLTAGE:     volt[15:12]  = 4'($urandom_range(1, 15));
         FLAW_CURRENT:     curr[15:12]  = 4'($urandom_range(1, 15));
         FLAW_TEMPERATURE: temp[15:12]  = 4'($urandom_range(1, 15));
         FLAW_SPARE:       spare[7:4]   = 4'($urandom_range(1, 15));
         default: ;
      endcase
      fill_frame(thr, pwm, rpm, volt, curr, temp, spare);
      send_frame();
   endtask

   // Finish any open frame, stop sending, wait out every pending result and
   // then the filter pipeline, so the block is idle.
   task automatic settle();
      while (frame_pos != 0) push_byte(8'($urandom_range(0, 255)));
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_alpha(input logic [ALPHA_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int phase_start;
      int pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // line noise while hunting: all dropped
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(SYNC_BYTE - 8'd1);
      push_byte(SYNC_BYTE + 8'd1);

      // reset alpha: full-scale frame with sync bytes as ordinary data,
      // then an all-zero frame to pull every average down (negative step)
      fill_frame(LIMIT_DUTY, LIMIT_DUTY, LIMIT_RPM, 16'h0F9B, 16'h0FFF, 16'h0FFF, 8'h0F);
      frame_body[0]  = SYNC_BYTE;
      frame_body[17] = SYNC_BYTE;
      send_frame();
      fill_frame(16'd0, 16'd0, 24'd0, 16'd0, 16'd0, 16'd0, 8'd0);
      send_frame();

      // no smoothing: averages jump to full scale, then each check alone
      // rejects a frame past its limit and the averages hold
      set_alpha(ALPHA_MAX);
      fill_frame(LIMIT_DUTY, LIMIT_DUTY, LIMIT_RPM, 16'h0FFF, 16'h0FFF, 16'h0FFF, 8'h0F);
      send_frame();
      fill_frame(LIMIT_DUTY + 16'd1, 16'd0, 24'd0, 16'd0, 16'd0, 16'd0, 8'd0);
      send_frame();
      fill_frame(16'd0, LIMIT_DUTY + 16'd1, 24'd0, 16'd0, 16'd0, 16'd0, 8'd0);
      send_frame();
      fill_frame(16'd0, 16'd0, LIMIT_RPM + 24'd1, 16'd0, 16'd0, 16'd0, 8'd0);
      send_frame();
      fill_frame(16'd0, 16'd0, 24'd0, 16'h1000, 16'd0, 16'd0, 8'd0);
      send_frame();
      fill_frame(16'd0, 16'd0, 24'd0, 16'd0, 16'hF000, 16'd0, 8'd0);
      send_frame();
      fill_frame(16'd0, 16'd0, 24'd0, 16'd0, 16'd0, 16'h8000, 8'd0);
      send_frame();
      fill_frame(16'd0, 16'd0, 24'd0, 16'd0, 16'd0, 16'd0, 8'h10);
      send_frame();
      // every field at its top value: all checks fail together
      foreach (frame_body[i]) frame_body[i] = 8'hFF;
      send_frame();

      // alpha zero freezes the averages; the largest alpha saturates
      set_alpha('0);
      send_sample_frame(FLAW_NONE);
      set_alpha('1);
      send_sample_frame(FLAW_NONE);

      // random part: mostly good frames, some flawed, random or noise
      for (int p = 0; p < 6; p++) begin
         set_alpha((p == 4) ? ALPHA_W'($urandom_range(0, 511)) : alpha_plan[p]);
         phase_start = frame_bytes_sent;
         while (frame_bytes_sent - phase_start < PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               send_sample_frame(FLAW_NONE);
            end else if (pick < 85) begin
               send_sample_frame(flaw_type'($urandom_range(1, 7)));
            end else if (pick < 93) begin
               foreach (frame_body[i]) frame_body[i] = 8'($urandom_range(0, 255));
               send_frame();
            end else begin
               repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
            end
         end
      end

      settle();
      repeat (16) @(posedge clock);

      $display("Covered %0d frame bytes and %0d dropped bytes over %0d alpha writes",
               frame_bytes_sent, dropped_bytes, settings_used);
      $display("Checked %0d frames, %0d passed the frame checks, %0d mismatches",
               frames_checked, frames_passed, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/etff_pkg.sv
hdl/etff_front.sv
hdl/etff_queue.sv
hdl/etff_ema_lane.sv
hdl/etff_back.sv
hdl/esc_telemetry_frame_filter_core.sv
bench/frame_filter_monitor.sv
bench/testbench.sv
